// ===== hw/rtl/eor_pkg.sv =====
package eor_pkg;

  localparam int RadiusBitsDef = 10;
  localparam int CoordBitsDef  = 16;

  // order in which the mirrored points of one iteration go out
  localparam logic [1:0] PtPlusPlus   = 2'd0;
  localparam logic [1:0] PtMinusMinus = 2'd1;
  localparam logic [1:0] PtMinusPlus  = 2'd2;
  localparam logic [1:0] PtPlusMinus  = 2'd3;

endpackage

// ===== hw/rtl/eor_mul.sv =====
module eor_mul #(
  parameter int W = 2 * eor_pkg::RadiusBitsDef + 4
) (
  input  logic             clk_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  output logic [2*W-1:0]   p_o
);

  logic [2*W-1:0] p_d;
  logic [2*W-1:0] p_q;

  assign p_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/ellipse_outline_rasterizer.sv =====
// Midpoint ellipse outline rasterizer.
// Input channel (in_valid_i / in_ready_o): req_type_i 0 loads a new ellipse from
// center_x_i, center_y_i, radius_x_i, radius_y_i and emits nothing; req_type_i 1
// runs one iteration of the midpoint loop. A step while no ellipse is active is
// taken and dropped. A start abandons any ellipse in progress.
// Output channel (out_valid_o / out_ready_i): one outline point per transfer, two
// or four per step; last_point_o marks the final point of the ellipse.
// Sequence: a start runs StSqX, StSqY, StDy and StInit, then the region-two entry
// StE1 to StE7 when a radius is zero. A step emits its points (2 or 4), then runs
// StUpd1 and StUpd2, plus the entry StE1 to StE7 at the switch to region two.
// Setup and the region switch are bound by the single registered
// multiplier, which is reused for every product.
// in_ready_o is high only while the sequencer is idle. The output register holds
// a point until it is taken; a stalled receiver stops point emission but the
// final point of a step may still wait while the next item is accepted.
// Reset (rst_ni low, asynchronous) leaves the block idle with no ellipse active
// and the output channel empty.
module ellipse_outline_rasterizer #(
  parameter int RADIUS_BITS = eor_pkg::RadiusBitsDef,
  parameter int COORD_BITS  = eor_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic signed [COORD_BITS-1:0] center_x_i,
  input  logic signed [COORD_BITS-1:0] center_y_i,
  input  logic [RADIUS_BITS-1:0]       radius_x_i,
  input  logic [RADIUS_BITS-1:0]       radius_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS:0]   pixel_x_o,
  output logic signed [COORD_BITS:0]   pixel_y_o,
  output logic                         last_point_o
);

  import eor_pkg::*;

  localparam int OffW  = RADIUS_BITS + 2;
  localparam int SqW   = 2 * RADIUS_BITS;
  localparam int StepW = 3 * RADIUS_BITS + 4;
  localparam int MulW  = 2 * RADIUS_BITS + 4;
  localparam int DecW  = 2 * MulW;
  localparam int OutW  = COORD_BITS + 1;
  localparam int SumW  = COORD_BITS + RADIUS_BITS + 3;

  typedef enum logic [3:0] {
    StIdle, StSqX, StSqY, StDy, StInit, StEmit, StUpd1, StUpd2,
    StE1, StE2, StE3, StE4, StE5, StE6, StE7
  } state_e;

  state_e                    state_q, state_d;
  logic                      active_q, active_d;
  logic                      region_two_q, region_two_d;
  logic                      br_q, br_d;
  logic [1:0]                pt_q, pt_d;
  logic signed [COORD_BITS-1:0] ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d;
  logic [RADIUS_BITS-1:0]    rx_q, rx_d, ry_q, ry_d;
  logic [SqW-1:0]            rad_x_sq_q, rad_x_sq_d, rad_y_sq_q, rad_y_sq_d;
  logic signed [OffW-1:0]    off_x_q, off_x_d, off_y_q, off_y_d;
  logic signed [StepW-1:0]   step_dx_q, step_dx_d, step_dy_q, step_dy_d;
  logic signed [DecW-1:0]    dec_q, dec_d;
  logic [MulW-1:0]           tmp_q, tmp_d;
  logic                      out_valid_q, out_valid_d;
  logic signed [OutW-1:0]    px_q, px_d, py_q, py_d;
  logic                      last_q, last_d;

  logic [MulW-1:0]           mul_a, mul_b;
  logic [DecW-1:0]           prod;
  logic signed [DecW-1:0]    rx2_dec, ry2_dec, dx_dec, dy_dec, add_dx, add_dy, add_sq;
  logic signed [StepW-1:0]   rx2_x2, ry2_x2;
  logic signed [OffW-1:0]    ym1, ym1_abs;
  logic                      four_pts, plus_x, plus_y, last_pt, take_dx, take_dy;
  logic signed [SumW-1:0]    sum_x, sum_y;

  eor_mul #(.W(MulW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign rx2_dec = DecW'(rad_x_sq_q);
  assign ry2_dec = DecW'(rad_y_sq_q);
  assign dx_dec  = DecW'(step_dx_q);
  assign dy_dec  = DecW'(step_dy_q);
  assign rx2_x2  = StepW'(rad_x_sq_q) << 1;
  assign ry2_x2  = StepW'(rad_y_sq_q) << 1;
  assign ym1     = off_y_q - OffW'(1);
  assign ym1_abs = ym1[OffW-1] ? -ym1 : ym1;

  // point selection for the output register
  assign four_pts = region_two_q ? (off_y_q != '0) : (off_x_q != '0);
  assign plus_x   = (pt_q == PtPlusPlus) || (pt_q == PtPlusMinus);
  assign plus_y   = (pt_q == PtPlusPlus) || (pt_q == PtMinusPlus);
  assign last_pt  = pt_q == (four_pts ? PtPlusMinus : PtMinusMinus);
  assign sum_x    = plus_x ? SumW'(ctr_x_q) + SumW'(off_x_q) : SumW'(ctr_x_q) - SumW'(off_x_q);
  assign sum_y    = plus_y ? SumW'(ctr_y_q) + SumW'(off_y_q) : SumW'(ctr_y_q) - SumW'(off_y_q);

  // decision update terms
  assign take_dx = !region_two_q || !br_q;
  assign take_dy = region_two_q || !br_q;
  assign add_dx  = take_dx ? dx_dec : '0;
  assign add_dy  = take_dy ? dy_dec : '0;
  assign add_sq  = region_two_q ? rx2_dec : ry2_dec;

  always_comb begin
    state_d      = state_q;
    active_d     = active_q;
    region_two_d = region_two_q;
    br_d         = br_q;
    pt_d         = pt_q;
    ctr_x_d      = ctr_x_q;
    ctr_y_d      = ctr_y_q;
    rx_d         = rx_q;
    ry_d         = ry_q;
    rad_x_sq_d   = rad_x_sq_q;
    rad_y_sq_d   = rad_y_sq_q;
    off_x_d      = off_x_q;
    off_y_d      = off_y_q;
    step_dx_d    = step_dx_q;
    step_dy_d    = step_dy_q;
    dec_d        = dec_q;
    tmp_d        = tmp_q;
    out_valid_d  = out_valid_q;
    px_d         = px_q;
    py_d         = py_q;
    last_d       = last_q;
    mul_a        = '0;
    mul_b        = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          if (!req_type_i) begin
            ctr_x_d      = center_x_i;
            ctr_y_d      = center_y_i;
            rx_d         = radius_x_i;
            ry_d         = radius_y_i;
            off_x_d      = '0;
            off_y_d      = OffW'(radius_y_i);
            step_dx_d    = '0;
            active_d     = 1'b1;
            region_two_d = 1'b0;
            state_d      = StSqX;
          end else if (active_q) begin
            pt_d    = PtPlusPlus;
            state_d = StEmit;
          end
        end
      end
      StSqX: begin
        mul_a   = MulW'(rx_q);
        mul_b   = MulW'(rx_q);
        state_d = StSqY;
      end
      StSqY: begin
        rad_x_sq_d = prod[SqW-1:0];
        mul_a      = MulW'(ry_q);
        mul_b      = MulW'(ry_q);
        state_d    = StDy;
      end
      StDy: begin
        rad_y_sq_d = prod[SqW-1:0];
        mul_a      = MulW'(rad_x_sq_q);
        mul_b      = MulW'(ry_q);
        state_d    = StInit;
      end
      StInit: begin
        step_dy_d = StepW'(prod) << 1;
        dec_d     = ry2_dec - prod + ((rx2_dec + DecW'(3)) >> 2);
        state_d   = (prod == '0) ? StE1 : StIdle;
      end
      StEmit: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          px_d        = sum_x[OutW-1:0];
          py_d        = sum_y[OutW-1:0];
          last_d      = region_two_q && (pt_q == PtMinusMinus) && !four_pts;
          pt_d        = pt_q + 2'd1;
          if (last_pt) begin
            state_d = StUpd1;
          end
        end
      end
      StUpd1: begin
        if (!region_two_q) begin
          br_d      = dec_q[DecW-1];
          off_x_d   = off_x_q + OffW'(1);
          step_dx_d = step_dx_q + ry2_x2;
          if (!dec_q[DecW-1]) begin
            off_y_d   = off_y_q - OffW'(1);
            step_dy_d = step_dy_q - rx2_x2;
          end
        end else begin
          br_d      = !dec_q[DecW-1] && (dec_q != '0);
          off_y_d   = off_y_q - OffW'(1);
          step_dy_d = step_dy_q - rx2_x2;
          if (dec_q[DecW-1] || (dec_q == '0)) begin
            off_x_d   = off_x_q + OffW'(1);
            step_dx_d = step_dx_q + ry2_x2;
          end
        end
        state_d = StUpd2;
      end
      StUpd2: begin
        dec_d = dec_q + add_dx - add_dy + add_sq;
        if (!region_two_q) begin
          state_d = (step_dx_q < step_dy_q) ? StIdle : StE1;
        end else begin
          active_d = !off_y_q[OffW-1];
          state_d  = StIdle;
        end
      end
      // region two entry: ry2*(ox*ox+ox+1) + rx2*(oy-1)^2 - rx2*ry2
      StE1: begin
        mul_a   = MulW'($unsigned(off_x_q));
        mul_b   = MulW'($unsigned(off_x_q));
        state_d = StE2;
      end
      StE2: begin
        tmp_d   = prod[MulW-1:0] + MulW'($unsigned(off_x_q)) + MulW'(1);
        state_d = StE3;
      end
      StE3: begin
        mul_a   = MulW'(rad_y_sq_q);
        mul_b   = tmp_q;
        state_d = StE4;
      end
      StE4: begin
        dec_d   = prod;
        mul_a   = MulW'($unsigned(ym1_abs));
        mul_b   = MulW'($unsigned(ym1_abs));
        state_d = StE5;
      end
      StE5: begin
        mul_a   = MulW'(rad_x_sq_q);
        mul_b   = prod[MulW-1:0];
        state_d = StE6;
      end
      StE6: begin
        dec_d   = dec_q + prod;
        mul_a   = MulW'(rad_x_sq_q);
        mul_b   = MulW'(rad_y_sq_q);
        state_d = StE7;
      end
      StE7: begin
        dec_d        = dec_q - prod;
        region_two_d = 1'b1;
        state_d      = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      active_q     <= 1'b0;
      region_two_q <= 1'b0;
      br_q         <= 1'b0;
      pt_q         <= '0;
      ctr_x_q      <= '0;
      ctr_y_q      <= '0;
      rx_q         <= '0;
      ry_q         <= '0;
      rad_x_sq_q   <= '0;
      rad_y_sq_q   <= '0;
      off_x_q      <= '0;
      off_y_q      <= '0;
      step_dx_q    <= '0;
      step_dy_q    <= '0;
      dec_q        <= '0;
      tmp_q        <= '0;
      out_valid_q  <= 1'b0;
      px_q         <= '0;
      py_q         <= '0;
      last_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      active_q     <= active_d;
      region_two_q <= region_two_d;
      br_q         <= br_d;
      pt_q         <= pt_d;
      ctr_x_q      <= ctr_x_d;
      ctr_y_q      <= ctr_y_d;
      rx_q         <= rx_d;
      ry_q         <= ry_d;
      rad_x_sq_q   <= rad_x_sq_d;
      rad_y_sq_q   <= rad_y_sq_d;
      off_x_q      <= off_x_d;
      off_y_q      <= off_y_d;
      step_dx_q    <= step_dx_d;
      step_dy_q    <= step_dy_d;
      dec_q        <= dec_d;
      tmp_q        <= tmp_d;
      out_valid_q  <= out_valid_d;
      px_q         <= px_d;
      py_q         <= py_d;
      last_q       <= last_d;
    end
  end

  assign in_ready_o   = (state_q == StIdle);
  assign out_valid_o  = out_valid_q;
  assign pixel_x_o    = px_q;
  assign pixel_y_o    = py_q;
  assign last_point_o = last_q;

endmodule

// ===== hw/rtl/eor_chk.sv =====
module eor_chk #(
  parameter int RADIUS_BITS = eor_pkg::RadiusBitsDef,
  parameter int COORD_BITS  = eor_pkg::CoordBitsDef
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         req_type_i,
  input logic signed [COORD_BITS-1:0] center_x_i,
  input logic signed [COORD_BITS-1:0] center_y_i,
  input logic [RADIUS_BITS-1:0]       radius_x_i,
  input logic [RADIUS_BITS-1:0]       radius_y_i,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [COORD_BITS:0]   pixel_x_o,
  input logic signed [COORD_BITS:0]   pixel_y_o,
  input logic                         last_point_o
);

  // stalled point holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_x_o) &&
      $stable(pixel_y_o) && $stable(last_point_o))
    else $error("output point changed while stalled");

  // setup of a new ellipse keeps the input side busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !req_type_i |=> !in_ready_o)
    else $error("input taken during ellipse setup");

  // new points only come out while an iteration is in progress
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o)
    else $error("point emitted while idle");

  // waiting input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(req_type_i) &&
      $stable(center_x_i) && $stable(center_y_i) && $stable(radius_x_i) &&
      $stable(radius_y_i))
    else $error("input item changed while waiting");

endmodule

bind ellipse_outline_rasterizer eor_chk #(
  .RADIUS_BITS (RADIUS_BITS),
  .COORD_BITS  (COORD_BITS)
) u_eor_chk (.*);

// ===== dv/ellipse_outline_rasterizer_tb.sv =====
`timescale 1ns / 100ps

module ellipse_outline_rasterizer_tb;
  import eor_pkg::*;

  localparam int CW = CoordBitsDef;
  localparam int RW = RadiusBitsDef;
  localparam bit ReqStart = 1'b0;
  localparam bit ReqStep = 1'b1;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 40;
  localparam int RandomItems = 260;

  typedef logic signed [CW:0] coord_t;

  typedef struct {
    bit                   kind;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic [RW-1:0]        rx;
    logic [RW-1:0]        ry;
  } draw_req_t;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   last;
  } outline_pt_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic req_type = ReqStart;
  logic signed [CW-1:0] center_x = '0;
  logic signed [CW-1:0] center_y = '0;
  logic [RW-1:0] radius_x = '0;
  logic [RW-1:0] radius_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  logic last_point;

  // shaping of idle cycles on both sides
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  outline_pt_t pending_pts[$];
  int mismatch_cnt = 0;
  int cycle_cnt = 0;

  // predicted block state
  bit                   ell_active = 1'b0;
  bit                   in_region_two = 1'b0;
  logic signed [CW-1:0] cen_x = '0;
  logic signed [CW-1:0] cen_y = '0;
  logic [2*RW-1:0]      rx_sq = '0;
  logic [2*RW-1:0]      ry_sq = '0;
  logic signed [11:0]   ofs_x = '0;
  logic signed [11:0]   ofs_y = '0;
  logic signed [33:0]   slope_x = '0;
  logic signed [33:0]   slope_y = '0;
  logic signed [47:0]   mid_err = '0;

  ellipse_outline_rasterizer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .radius_x_i  (radius_x),
    .radius_y_i  (radius_y),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pixel_x_o   (pixel_x),
    .pixel_y_o   (pixel_y),
    .last_point_o(last_point)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic void push_mirror(logic [1:0] which, bit is_last);
    longint sgx;
    longint sgy;
    outline_pt_t p;
    sgx = 1;
    sgy = 1;
    case (which)
      PtPlusPlus: begin
        sgx = 1;
        sgy = 1;
      end
      PtMinusMinus: begin
        sgx = -1;
        sgy = -1;
      end
      PtMinusPlus: begin
        sgx = -1;
        sgy = 1;
      end
      PtPlusMinus: begin
        sgx = 1;
        sgy = -1;
      end
      default: begin
        sgx = 1;
        sgy = 1;
      end
    endcase
    p.px = coord_t'(longint'(cen_x) + sgx * longint'(ofs_x));
    p.py = coord_t'(longint'(cen_y) + sgy * longint'(ofs_y));
    p.last = is_last;
    pending_pts.push_back(p);
  endfunction

  function automatic void enter_region_two();
    longint ox;
    longint ym1;
    ox = longint'(ofs_x);
    ym1 = longint'(ofs_y) - 1;
    in_region_two = 1'b1;
    mid_err = 48'(longint'(ry_sq) * (ox * ox + ox + 1) + longint'(rx_sq) * (ym1 * ym1)
            - longint'(rx_sq) * longint'(ry_sq));
  endfunction

  function automatic void predict_outline(draw_req_t r);
    longint rx2;
    longint ry2;
    longint sx;
    longint sy;
    longint d;
    bit fin;
    if (r.kind == ReqStart) begin
      rx2 = longint'(r.rx) * longint'(r.rx);
      ry2 = longint'(r.ry) * longint'(r.ry);
      cen_x = r.cx;
      cen_y = r.cy;
      rx_sq = (2*RW)'(rx2);
      ry_sq = (2*RW)'(ry2);
      ofs_x = '0;
      ofs_y = 12'(r.ry);
      mid_err = 48'(ry2 - rx2 * longint'(r.ry) + ((rx2 + 3) >>> 2));
      slope_x = '0;
      slope_y = 34'(2 * rx2 * longint'(r.ry));
      ell_active = 1'b1;
      in_region_two = 1'b0;
      if (!(slope_x < slope_y)) enter_region_two();
      return;
    end
    if (!ell_active) return;
    rx2 = longint'(rx_sq);
    ry2 = longint'(ry_sq);
    sx = longint'(slope_x);
    sy = longint'(slope_y);
    d = longint'(mid_err);
    if (!in_region_two) begin
      push_mirror(PtPlusPlus, 1'b0);
      push_mirror(PtMinusMinus, 1'b0);
      if (ofs_x != 0) begin
        push_mirror(PtMinusPlus, 1'b0);
        push_mirror(PtPlusMinus, 1'b0);
      end
      if (d < 0) begin
        sx += 2 * ry2;
        d += sx + ry2;
      end else begin
        ofs_y = ofs_y - 12'sd1;
        sx += 2 * ry2;
        sy -= 2 * rx2;
        d += sx - sy + ry2;
      end
      ofs_x = ofs_x + 12'sd1;
      slope_x = 34'(sx);
      slope_y = 34'(sy);
      mid_err = 48'(d);
      if (!(slope_x < slope_y)) enter_region_two();
    end else begin
      fin = (ofs_y <= 0);
      push_mirror(PtPlusPlus, 1'b0);
      push_mirror(PtMinusMinus, fin);
      if (ofs_y != 0) begin
        push_mirror(PtMinusPlus, 1'b0);
        push_mirror(PtPlusMinus, 1'b0);
      end
      if (d > 0) begin
        sy -= 2 * rx2;
        d += rx2 - sy;
      end else begin
        ofs_x = ofs_x + 12'sd1;
        sx += 2 * ry2;
        sy -= 2 * rx2;
        d += sx - sy + rx2;
      end
      ofs_y = ofs_y - 12'sd1;
      slope_x = 34'(sx);
      slope_y = 34'(sy);
      mid_err = 48'(d);
      if (ofs_y < 0) ell_active = 1'b0;
    end
  endfunction

  task automatic send_item(draw_req_t r);
    while (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    req_type <= r.kind;
    center_x <= r.cx;
    center_y <= r.cy;
    radius_x <= r.rx;
    radius_y <= r.ry;
    do @(posedge clk_i); while (!in_ready);
    predict_outline(r);
  endtask

  task automatic start_ellipse(logic signed [CW-1:0] cx, logic signed [CW-1:0] cy,
                               logic [RW-1:0] rx, logic [RW-1:0] ry);
    draw_req_t r;
    r.kind = ReqStart;
    r.cx = cx;
    r.cy = cy;
    r.rx = rx;
    r.ry = ry;
    send_item(r);
  endtask

  // geometry fields are don't-care on a step, so they carry noise
  task automatic step_once();
    draw_req_t r;
    r.kind = ReqStep;
    r.cx = CW'($urandom);
    r.cy = CW'($urandom);
    r.rx = RW'($urandom);
    r.ry = RW'($urandom);
    send_item(r);
  endtask

  task automatic run_to_end();
    while (ell_active) step_once();
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 25);
      end
    end
  end

  always @(posedge clk_i) begin
    outline_pt_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_pts.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected point: got (%0d, %0d) last %0b", pixel_x, pixel_y, last_point);
      end else begin
        want = pending_pts.pop_front();
        if (pixel_x !== want.px || pixel_y !== want.py || last_point !== want.last) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("point mismatch: expected (%0d, %0d) last %0b, got (%0d, %0d) last %0b",
                     want.px, want.py, want.last, pixel_x, pixel_y, last_point);
        end
      end
    end
  end

  task automatic test_idle_steps();
    step_once();
    step_once();
  endtask

  task automatic test_degenerate_radii();
    // both radii zero: center comes out twice
    start_ellipse(-16'sd32768, 16'sd32767, '0, '0);
    run_to_end();
    step_once();
    start_ellipse(16'sd32767, -16'sd32768, '0, 10'd3);
    run_to_end();
    start_ellipse(16'sd100, -16'sd100, 10'd5, '0);
    run_to_end();
  endtask

  task automatic test_field_extremes();
    start_ellipse(16'sd32767, -16'sd32768, 10'd1023, 10'd1023);
    repeat (4) step_once();
    // new start abandons the ellipse in progress
    start_ellipse(-16'sd5, 16'sd7, 10'd3, 10'd2);
    run_to_end();
    start_ellipse(-16'sd32768, -16'sd32768, '0, 10'd1023);
    repeat (2) step_once();
    start_ellipse(16'sd32767, 16'sd32767, 10'd1023, '0);
    run_to_end();
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    start_ellipse(16'sd40, 16'sd20, 10'd9, 10'd7);
    run_to_end();
  endtask

  task automatic test_random_ellipses();
    int done_items;
    int n_steps;
    int pick;
    done_items = 0;
    while (done_items < RandomItems) begin
      quiet = (done_items >= 100 && done_items < 150);
      pick = $urandom_range(99);
      if (pick < 8) begin
        if (ell_active) done_items++;
        step_once();
      end else if (pick < 16) begin
        start_ellipse(CW'($urandom), CW'($urandom), RW'($urandom), RW'($urandom));
        done_items++;
        n_steps = $urandom_range(1, 5);
        repeat (n_steps) begin
          if (ell_active) done_items++;
          step_once();
        end
      end else begin
        start_ellipse(CW'($urandom), CW'($urandom), RW'($urandom_range(0, 15)),
                      RW'($urandom_range(0, 15)));
        done_items++;
        n_steps = ($urandom_range(99) < 15) ? $urandom_range(1, 6) : 4096;
        while (ell_active && n_steps > 0) begin
          step_once();
          done_items++;
          n_steps--;
        end
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_steps();
    test_degenerate_radii();
    test_field_extremes();
    test_output_backpressure();
    test_random_ellipses();
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
